/* rtl/sha_pkg.sv */
// Shared types, constants and tables of the SHA-256 hash engine.
`timescale 1ns / 1ps

package sha_pkg;

    localparam int BLK_WORDS   = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] SHA_IV [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPD_RD,
        ST_UPD_ADD
    } sha_state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_FINAL,
        BLK_LENGTH
    } blk_kind_t;

    typedef struct packed {
        logic load_w;
        logic load_v;
        logic round_en;
        logic shift_v;
    } core_ctrl_t;

endpackage

/* rtl/sha_if.sv */
// Valid/ready channel interfaces for message bytes and digest words.
`timescale 1ns / 1ps

interface sha_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, message_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sha_core.sv */
// Message schedule and working variables with the one-round-per-cycle datapath.
`timescale 1ns / 1ps

module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  core_ctrl_t  ctrl,
    input  logic [31:0] word_in,
    input  logic [31:0] chain_in,
    input  logic [31:0] kconst,
    output logic [31:0] v0
);

    logic [31:0] w_reg [BLK_WORDS];
    logic [31:0] w_next [BLK_WORDS];
    logic [31:0] v_reg [CHAIN_WORDS];
    logic [31:0] v_next [CHAIN_WORDS];

    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] sched_new;
    logic [31:0] w_in;
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        s0        = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1        = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        sched_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_in      = ctrl.load_w ? word_in : sched_new;

        big1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big1 + choose + kconst + w_reg[0];
        big0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big0 + major;
    end

    always_comb
    begin
        w_next = w_reg;
        if (ctrl.load_w || ctrl.round_en)
        begin
            for (int j = 0; j < BLK_WORDS - 1; j++)
            begin
                w_next[j] = w_reg[j + 1];
            end
            w_next[BLK_WORDS - 1] = w_in;
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (ctrl.load_v || ctrl.shift_v)
        begin
            for (int j = 0; j < CHAIN_WORDS - 1; j++)
            begin
                v_next[j] = v_reg[j + 1];
            end
            v_next[CHAIN_WORDS - 1] = chain_in;
        end
        else if (ctrl.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    assign v0 = v_reg[0];

endmodule

/* rtl/sha256_hash_engine.sv */
// SHA-256 hash engine top level: byte intake, padding, block sequencing, digest output.
//
//  channel  dir  payload                                   transaction
//  msg      in   message_byte, byte_present, end_of_msg    one byte and/or end mark
//  digest   out  digest_word, word_index, last_word        one digest word, 8 per msg
//
// A byte is taken only while idle. A full block or an end mark runs a compression: load the
// block and chaining RAMs, 64 rounds, then fold the result back into the chaining RAM (or, on
// the last block, out as the digest); an end with 56 or more bytes buffered runs two blocks.
// Digest words leave one per read-and-add step of the update, paced by digest.ready.
// Reset clears the chaining valid bits, so the chaining RAM reads as the initial hash.
`timescale 1ns / 1ps

module sha256_hash_engine
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sha_msg_if.sink  msg,
    sha_dig_if.source digest
);

    sha_state_t  state_reg;
    sha_state_t  state_next;
    blk_kind_t   kind_reg;
    logic        fin_pend_reg;
    logic [4:0]  load_cnt_reg;
    logic [5:0]  rnd_cnt_reg;
    logic [2:0]  upd_idx_reg;
    logic [5:0]  fill_reg;
    logic [54:0] blocks_reg;
    logic [23:0] part_reg;
    logic [7:0]  chain_vld_reg;

    logic        chain_vld_q_reg;
    logic [2:0]  chain_idx_q_reg;

    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;

    logic        msg_ready;
    logic        msg_acc;
    logic        blk_we;
    logic        blk_re;
    logic [31:0] blk_q;
    logic        chain_re;
    logic        chain_we;
    logic [2:0]  chain_raddr;
    logic [31:0] chain_q;
    logic [31:0] chain_val;
    logic [31:0] chain_sum;
    logic        out_free;
    logic        out_load;
    logic        last_blk;
    logic        upd_adv;
    logic        upd_done;
    logic        msg_done;
    logic        starts_blk;
    core_ctrl_t  core_ctrl;
    logic [31:0] v0;
    logic [4:0]  cnt_m1;
    logic [3:0]  widx;
    logic [31:0] pad_word;
    logic [31:0] len_hi;
    logic [31:0] len_lo;
    logic [31:0] word_in;
    logic        len_fits;

    sha_ram #(
        .WIDTH (32),
        .DEPTH (BLK_WORDS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (fill_reg[5:2]),
        .wdata ({part_reg, msg.message_byte}),
        .re    (blk_re),
        .raddr (load_cnt_reg[3:0]),
        .rdata (blk_q)
    );

    sha_ram #(
        .WIDTH (32),
        .DEPTH (CHAIN_WORDS)
    ) u_chain_ram (
        .clk   (clk),
        .we    (chain_we),
        .waddr (upd_idx_reg),
        .wdata (chain_sum),
        .re    (chain_re),
        .raddr (chain_raddr),
        .rdata (chain_q)
    );

    sha_core u_core (
        .clk      (clk),
        .ctrl     (core_ctrl),
        .word_in  (word_in),
        .chain_in (chain_val),
        .kconst   (SHA_K[rnd_cnt_reg]),
        .v0       (v0)
    );

    assign msg_acc    = msg.valid && msg_ready;
    assign blk_we     = msg_acc && msg.byte_present && (fill_reg[1:0] == 2'b11);
    assign starts_blk = (msg.byte_present && (fill_reg == 6'd63)) || msg.end_of_message;
    assign len_fits   = (fill_reg[5:3] != 3'b111);
    assign last_blk   = (kind_reg == BLK_LENGTH) || ((kind_reg == BLK_FINAL) && len_fits);
    assign out_free   = !out_valid_reg || digest.ready;
    assign upd_adv    = !last_blk || out_free;
    assign upd_done   = (state_reg == ST_UPD_ADD) && upd_adv && (upd_idx_reg == 3'd7);
    assign msg_done   = upd_done && last_blk;
    assign chain_val  = chain_vld_q_reg ? chain_q : SHA_IV[chain_idx_q_reg];
    assign chain_sum  = chain_val + v0;

    // block word assembly with pad and length
    assign cnt_m1 = load_cnt_reg - 5'd1;
    assign widx   = cnt_m1[3:0];
    assign len_hi = blocks_reg[54:23];
    assign len_lo = {blocks_reg[22:0], fill_reg, 3'b000};

    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h000000};
            2'd1:    pad_word = {part_reg[7:0], PAD_BYTE, 16'h0000};
            2'd2:    pad_word = {part_reg[15:0], PAD_BYTE, 8'h00};
            2'd3:    pad_word = {part_reg[23:0], PAD_BYTE};
            default: pad_word = 32'h0;
        endcase
    end

    always_comb
    begin
        word_in = 32'h0;
        case (kind_reg)
            BLK_DATA:
            begin
                word_in = blk_q;
            end
            BLK_FINAL:
            begin
                if (widx < fill_reg[5:2])
                begin
                    word_in = blk_q;
                end
                else if (widx == fill_reg[5:2])
                begin
                    word_in = pad_word;
                end
                else if (len_fits && (widx == 4'd14))
                begin
                    word_in = len_hi;
                end
                else if (len_fits && (widx == 4'd15))
                begin
                    word_in = len_lo;
                end
            end
            BLK_LENGTH:
            begin
                if (widx == 4'd14)
                begin
                    word_in = len_hi;
                end
                else if (widx == 4'd15)
                begin
                    word_in = len_lo;
                end
            end
            default:
            begin
                word_in = 32'h0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc && starts_blk)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (load_cnt_reg == 5'd16)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_cnt_reg == 6'd63)
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD_ADD;
            end
            ST_UPD_ADD:
            begin
                if (upd_adv)
                begin
                    if (upd_idx_reg != 3'd7)
                    begin
                        state_next = ST_UPD_RD;
                    end
                    else if (last_blk || ((kind_reg == BLK_DATA) && !fin_pend_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        msg_ready   = 1'b0;
        blk_re      = 1'b0;
        chain_re    = 1'b0;
        chain_we    = 1'b0;
        chain_raddr = upd_idx_reg;
        out_load    = 1'b0;
        core_ctrl   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
            end
            ST_LOAD:
            begin
                blk_re           = !load_cnt_reg[4];
                chain_re         = (load_cnt_reg < 5'd8);
                chain_raddr      = load_cnt_reg[2:0];
                core_ctrl.load_w = (load_cnt_reg != 5'd0);
                core_ctrl.load_v = (load_cnt_reg != 5'd0) && (load_cnt_reg <= 5'd8);
            end
            ST_ROUND:
            begin
                core_ctrl.round_en = 1'b1;
            end
            ST_UPD_RD:
            begin
                chain_re = 1'b1;
            end
            ST_UPD_ADD:
            begin
                core_ctrl.shift_v = upd_adv;
                chain_we          = !last_blk;
                out_load          = last_blk && out_free;
            end
            default:
            begin
                msg_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= BLK_DATA;
            fin_pend_reg  <= 1'b0;
            load_cnt_reg  <= 5'd0;
            rnd_cnt_reg   <= 6'd0;
            upd_idx_reg   <= 3'd0;
            fill_reg      <= 6'd0;
            blocks_reg    <= 55'd0;
            chain_vld_reg <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (msg_acc)
            begin
                if (msg.byte_present)
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        blocks_reg <= blocks_reg + 55'd1;
                    end
                end
                if (starts_blk)
                begin
                    kind_reg     <= (msg.byte_present && (fill_reg == 6'd63)) ?
                                    BLK_DATA : BLK_FINAL;
                    fin_pend_reg <= msg.end_of_message;
                end
            end

            if (state_reg == ST_LOAD)
            begin
                load_cnt_reg <= (load_cnt_reg == 5'd16) ? 5'd0 : load_cnt_reg + 5'd1;
            end

            if (state_reg == ST_ROUND)
            begin
                rnd_cnt_reg <= rnd_cnt_reg + 6'd1;
            end

            if ((state_reg == ST_UPD_ADD) && upd_adv)
            begin
                upd_idx_reg <= upd_idx_reg + 3'd1;
            end

            if (chain_we)
            begin
                chain_vld_reg[upd_idx_reg] <= 1'b1;
            end

            if (upd_done && !last_blk)
            begin
                kind_reg <= (kind_reg == BLK_DATA) ? BLK_FINAL : BLK_LENGTH;
            end

            if (msg_done)
            begin
                fill_reg      <= 6'd0;
                blocks_reg    <= 55'd0;
                chain_vld_reg <= 8'h00;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digest.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_acc && msg.byte_present)
        begin
            part_reg <= {part_reg[15:0], msg.message_byte};
        end
        if (chain_re)
        begin
            chain_vld_q_reg <= chain_vld_reg[chain_raddr];
            chain_idx_q_reg <= chain_raddr;
        end
        if (out_load)
        begin
            out_word_reg <= chain_sum;
            out_idx_reg  <= upd_idx_reg;
            out_last_reg <= (upd_idx_reg == 3'd7);
        end
    end

    assign msg.ready          = msg_ready;
    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = out_last_reg;

`ifndef SYNTHESIS
    a_last_on_seven: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (digest.last_word == (digest.word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_blk_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
        !(blk_we && blk_re))
        else $error("block buffer written while being loaded");

    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_cnt_reg == 6'd63) |=> (state_reg == ST_UPD_RD))
        else $error("compression did not end after 64 rounds");

    a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !msg.ready)
        else $error("byte taken while a block is in progress");
`endif

endmodule
